/* rtl/dllp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dllp_pkg - shared types and codes for the linked list pool
// request kinds, result status codes and payload widths
// ----------------------------------------------------------------------------
package dllp_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // request kinds
    localparam kind_t KIND_INS_HEAD   = 3'd0;
    localparam kind_t KIND_INS_TAIL   = 3'd1;
    localparam kind_t KIND_INS_AFTER  = 3'd2;
    localparam kind_t KIND_INS_BEFORE = 3'd3;
    localparam kind_t KIND_READ_OUT   = 3'd4;

    // result status codes
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_NO_FREE   = 2'd1;
    localparam status_t STAT_NOT_FOUND = 2'd2;
    localparam status_t STAT_EMPTY     = 2'd3;

endpackage : dllp_pkg
`default_nettype wire

/* rtl/dllp_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dllp_ifs - request and result channels of the linked list pool
// valid/ready channels, a transfer happens when both are high at a clock edge
// ----------------------------------------------------------------------------
interface dllp_req_if;
    logic                  valid;
    logic                  ready;
    dllp_pkg::kind_t       kind;
    dllp_pkg::data_t       value;
    dllp_pkg::data_t       key;

    modport source (output valid, output kind, output value, output key, input ready);
    modport sink   (input valid, input kind, input value, input key, output ready);
endinterface : dllp_req_if

interface dllp_rsp_if;
    logic                  valid;
    logic                  ready;
    dllp_pkg::status_t     status;
    dllp_pkg::data_t       element;
    logic                  last;

    modport source (output valid, output status, output element, output last, input ready);
    modport sink   (input valid, input status, input element, input last, output ready);
endinterface : dllp_rsp_if
`default_nettype wire

/* rtl/doubly_linked_list_pool.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// doubly_linked_list_pool - doubly linked list kept in a fixed node pool
// insert at head, tail, after or before a key, and read the list out
// ----------------------------------------------------------------------------
// One request is taken at a time; req.ready is high only while the sequencer
// is idle. Node values, forward links and backward links sit in three small
// RAMs with registered read, and one link is followed per clock cycle. An
// insert at the head writes the new node, then points its neighbors at it,
// then loads the result. An insert at the tail, after or before a key first
// walks the list, at most POOL_NODES nodes, and then does the same; a missing
// key ends the walk with its result. A read out gives one result per cycle
// as long as the result side keeps rsp.ready high. Nodes are never released,
// so the free list is simply the next unused pool index. Results wait in an
// output register; a stalled result side stalls a read out but loses nothing.
// Status 1 reports a full pool, 2 a missing key and 3 a read out of an empty
// list. Request kinds 5 to 7 are dropped without a result.
// ----------------------------------------------------------------------------
module doubly_linked_list_pool #(
    parameter int POOL_NODES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dllp_req_if.sink   req,
    dllp_rsp_if.source rsp
);

    import dllp_pkg::*;

    // link width holds the null code (POOL_NODES), index width addresses nodes
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    typedef logic [LW-1:0] link_t;

    localparam link_t NIL = LW'(POOL_NODES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_TAIL_WALK,
        ST_WR_NODE,
        ST_FIX,
        ST_EMIT
    } state_t;

    function automatic logic is_node(input link_t l);
        return l < NIL;
    endfunction

    // sequencer and list registers
    state_t  state_reg,        state_next;
    kind_t   kind_reg,         kind_next;
    data_t   value_reg,        value_next;
    data_t   key_reg,          key_next;
    link_t   head_reg,         head_next;
    link_t   free_reg,         free_next;
    link_t   p_reg,            p_next;
    link_t   new_next_reg,     new_next_next;
    link_t   new_prev_reg,     new_prev_next;
    logic    fix_next_en_reg,  fix_next_en_next;
    link_t   fix_next_at_reg,  fix_next_at_next;
    logic    fix_prev_en_reg,  fix_prev_en_next;
    link_t   fix_prev_at_reg,  fix_prev_at_next;
    logic    set_head_reg,     set_head_next;
    status_t res_status_reg,   res_status_next;

    // output register
    logic    rsp_valid_reg,    rsp_valid_next;
    status_t rsp_status_reg,   rsp_status_next;
    data_t   rsp_element_reg,  rsp_element_next;
    logic    rsp_last_reg,     rsp_last_next;

    // ram ports
    logic          rd_en;
    link_t         rd_link;
    logic [IW-1:0] rd_addr;
    logic [DATA_W-1:0] value_q;
    link_t         next_q;
    link_t         prev_q;

    logic          val_wr_en;
    logic          nxt_wr_en;
    link_t         nxt_wr_at;
    link_t         nxt_wr_data;
    logic          prv_wr_en;
    link_t         prv_wr_at;
    link_t         prv_wr_data;

    logic          slot_free;
    logic          key_hit;

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.element = rsp_element_reg;
    assign rsp.last    = rsp_last_reg;

    // all reads share one address: the head at the start of a walk, else the
    // link just read
    assign rd_link = (state_reg == ST_IDLE) ? head_reg : next_q;
    assign rd_addr = rd_link[IW-1:0];

    assign slot_free = !rsp_valid_reg || rsp.ready;

    // shared key compare
    assign key_hit = (value_q == key_reg);

    dllp_ram #(.WIDTH(DATA_W), .DEPTH(POOL_NODES)) u_value_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (free_reg[IW-1:0]),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (value_q)
    );

    dllp_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next_ram (
        .clk     (clk),
        .wr_en   (nxt_wr_en),
        .wr_addr (nxt_wr_at[IW-1:0]),
        .wr_data (nxt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (next_q)
    );

    dllp_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prv_wr_en),
        .wr_addr (prv_wr_at[IW-1:0]),
        .wr_data (prv_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prev_q)
    );

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        key_next         = key_reg;
        head_next        = head_reg;
        free_next        = free_reg;
        p_next           = p_reg;
        new_next_next    = new_next_reg;
        new_prev_next    = new_prev_reg;
        fix_next_en_next = fix_next_en_reg;
        fix_next_at_next = fix_next_at_reg;
        fix_prev_en_next = fix_prev_en_reg;
        fix_prev_at_next = fix_prev_at_reg;
        set_head_next    = set_head_reg;
        res_status_next  = res_status_reg;

        // a transfer empties the output register unless it is loaded again
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_element_next = rsp_element_reg;
        rsp_last_next    = rsp_last_reg;

        rd_en       = 1'b0;
        val_wr_en   = 1'b0;
        nxt_wr_en   = 1'b0;
        nxt_wr_at   = free_reg;
        nxt_wr_data = new_next_reg;
        prv_wr_en   = 1'b0;
        prv_wr_at   = free_reg;
        prv_wr_data = new_prev_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next        = req.kind;
                    value_next       = req.value;
                    key_next         = req.key;
                    fix_next_en_next = 1'b0;
                    fix_prev_en_next = 1'b0;
                    set_head_next    = 1'b0;
                    p_next           = head_reg;
                    if (req.kind == KIND_READ_OUT)
                    begin
                        if (is_node(head_reg))
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_EMIT;
                        end
                    end
                    else if (req.kind < KIND_READ_OUT)
                    begin
                        if (!is_node(free_reg))
                        begin
                            // full pool wins over the key search
                            res_status_next = STAT_NO_FREE;
                            state_next      = ST_EMIT;
                        end
                        else if (req.kind == KIND_INS_HEAD)
                        begin
                            new_next_next    = head_reg;
                            new_prev_next    = NIL;
                            fix_prev_en_next = is_node(head_reg);
                            fix_prev_at_next = head_reg;
                            set_head_next    = 1'b1;
                            state_next       = ST_WR_NODE;
                        end
                        else if (!is_node(head_reg))
                        begin
                            if (req.kind == KIND_INS_TAIL)
                            begin
                                // empty list, the new node becomes the head
                                new_next_next = NIL;
                                new_prev_next = NIL;
                                set_head_next = 1'b1;
                                state_next    = ST_WR_NODE;
                            end
                            else
                            begin
                                res_status_next = STAT_NOT_FOUND;
                                state_next      = ST_EMIT;
                            end
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = (req.kind == KIND_INS_TAIL) ? ST_TAIL_WALK
                                                                     : ST_SEARCH;
                        end
                    end
                end
            end

            ST_READ:
            begin
                // ram output holds node p while the output side stalls
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = STAT_OK;
                    rsp_element_next = value_q;
                    rsp_last_next    = !is_node(next_q);
                    if (is_node(next_q))
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (key_hit)
                begin
                    if (kind_reg == KIND_INS_AFTER)
                    begin
                        new_next_next    = next_q;
                        new_prev_next    = p_reg;
                        fix_next_en_next = 1'b1;
                        fix_next_at_next = p_reg;
                        fix_prev_en_next = is_node(next_q);
                        fix_prev_at_next = next_q;
                    end
                    else
                    begin
                        new_next_next    = p_reg;
                        new_prev_next    = prev_q;
                        fix_next_en_next = is_node(prev_q);
                        fix_next_at_next = prev_q;
                        set_head_next    = !is_node(prev_q);
                        fix_prev_en_next = 1'b1;
                        fix_prev_at_next = p_reg;
                    end
                    state_next = ST_WR_NODE;
                end
                else if (is_node(next_q))
                begin
                    rd_en  = 1'b1;
                    p_next = next_q;
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = ST_EMIT;
                end
            end

            ST_TAIL_WALK:
            begin
                if (is_node(next_q))
                begin
                    rd_en  = 1'b1;
                    p_next = next_q;
                end
                else
                begin
                    new_next_next    = NIL;
                    new_prev_next    = p_reg;
                    fix_next_en_next = 1'b1;
                    fix_next_at_next = p_reg;
                    state_next       = ST_WR_NODE;
                end
            end

            ST_WR_NODE:
            begin
                // fill the new node taken from the free pool
                val_wr_en  = 1'b1;
                nxt_wr_en  = 1'b1;
                prv_wr_en  = 1'b1;
                state_next = ST_FIX;
            end

            ST_FIX:
            begin
                // point the neighbors at the new node
                nxt_wr_en   = fix_next_en_reg;
                nxt_wr_at   = fix_next_at_reg;
                nxt_wr_data = free_reg;
                prv_wr_en   = fix_prev_en_reg;
                prv_wr_at   = fix_prev_at_reg;
                prv_wr_data = free_reg;
                if (set_head_reg)
                begin
                    head_next = free_reg;
                end
                free_next       = free_reg + LW'(1);
                res_status_next = STAT_OK;
                state_next      = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_element_next = '0;
                    rsp_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NIL;
            free_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        key_reg         <= key_next;
        p_reg           <= p_next;
        new_next_reg    <= new_next_next;
        new_prev_reg    <= new_prev_next;
        fix_next_en_reg <= fix_next_en_next;
        fix_next_at_reg <= fix_next_at_next;
        fix_prev_en_reg <= fix_prev_en_next;
        fix_prev_at_reg <= fix_prev_at_next;
        set_head_reg    <= set_head_next;
        res_status_reg  <= res_status_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_element_reg <= rsp_element_next;
        rsp_last_reg    <= rsp_last_next;
    end

endmodule : doubly_linked_list_pool
`default_nettype wire

/* rtl/dllp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dllp_ram - generic single write, single read RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dllp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : dllp_ram
`default_nettype wire

/* tb/list_pool_sb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_pool_sb_pkg - result tracking for the linked list pool bench
// mirrors the node pool, links and free list, and queues the results
// that each accepted request should produce
// ----------------------------------------------------------------------------
package list_pool_sb_pkg;

    import dllp_pkg::*;

    typedef struct {
        status_t status;
        data_t   element;
        logic    last;
    } list_result_t;

    class list_pool_scoreboard #(int NODES = 16);

        list_result_t awaited[$];
        data_t        node_val[NODES];
        int           next_of[NODES];
        int           prev_of[NODES];
        int           list_head;
        int           free_head;
        int           errors;

        // reset state: every node chained as free, list empty
        function new();
            for (int i = 0; i < NODES; i++)
            begin
                node_val[i] = '0;
                next_of[i]  = i + 1;
                prev_of[i]  = NODES;
            end
            list_head = NODES;
            free_head = 0;
            errors    = 0;
        endfunction

        function void await_result(status_t status, data_t element, logic last);
            list_result_t r;
            r.status  = status;
            r.element = element;
            r.last    = last;
            awaited.push_back(r);
        endfunction

        // update the mirrored pool for one accepted request
        function void apply_request(kind_t kind, data_t value, data_t key);
            int p;
            int q;
            int n;
            int hit;
            int steps;
            if (kind == KIND_READ_OUT)
            begin
                p = list_head;
                if (p >= NODES)
                begin
                    await_result(STAT_EMPTY, '0, 1'b1);
                    return;
                end
                steps = 0;
                while (p < NODES && steps < NODES)
                begin
                    q = next_of[p];
                    await_result(STAT_OK, node_val[p], (q >= NODES) || (steps + 1 >= NODES));
                    steps++;
                    p = q;
                end
                return;
            end
            if (kind > KIND_READ_OUT)
                return;
            // a full pool wins over the key search
            if (free_head >= NODES)
            begin
                await_result(STAT_NO_FREE, '0, 1'b1);
                return;
            end
            hit = NODES;
            if (kind == KIND_INS_AFTER || kind == KIND_INS_BEFORE)
            begin
                p     = list_head;
                steps = 0;
                while (p < NODES && steps < NODES && hit == NODES)
                begin
                    if (node_val[p] == key)
                        hit = p;
                    else
                        p = next_of[p];
                    steps++;
                end
                if (hit == NODES)
                begin
                    await_result(STAT_NOT_FOUND, '0, 1'b1);
                    return;
                end
            end
            n           = free_head;
            free_head   = (next_of[n] < NODES) ? next_of[n] : NODES;
            node_val[n] = value;
            next_of[n]  = NODES;
            prev_of[n]  = NODES;
            case (kind)
                KIND_INS_HEAD:
                begin
                    next_of[n] = list_head;
                    if (list_head < NODES)
                        prev_of[list_head] = n;
                    list_head = n;
                end
                KIND_INS_TAIL:
                begin
                    if (list_head >= NODES)
                        list_head = n;
                    else
                    begin
                        p     = list_head;
                        steps = 0;
                        while (next_of[p] < NODES && steps < NODES)
                        begin
                            p = next_of[p];
                            steps++;
                        end
                        next_of[p] = n;
                        prev_of[n] = p;
                    end
                end
                KIND_INS_AFTER:
                begin
                    q          = next_of[hit];
                    next_of[n] = q;
                    prev_of[n] = hit;
                    if (q < NODES)
                        prev_of[q] = n;
                    next_of[hit] = n;
                end
                default:
                begin
                    q          = prev_of[hit];
                    next_of[n] = hit;
                    prev_of[n] = q;
                    if (q < NODES)
                        next_of[q] = n;
                    else
                        list_head = n;
                    prev_of[hit] = n;
                end
            endcase
            await_result(STAT_OK, '0, 1'b1);
        endfunction

        function void check_result(status_t status, data_t element, logic last);
            list_result_t exp_r;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing awaited: status %0d element %0d last %0b",
                         $time, status, element, last);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            if (status !== exp_r.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_r.status, status);
                errors++;
            end
            if (element !== exp_r.element)
            begin
                $display("%0t: element mismatch: expected %0d actual %0d",
                         $time, exp_r.element, element);
                errors++;
            end
            if (last !== exp_r.last)
            begin
                $display("%0t: last mismatch: expected %0b actual %0b",
                         $time, exp_r.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage : list_pool_sb_pkg

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - bench for the doubly linked list pool
// directed inserts and read outs, then random requests, with idling on the
// request side and stalls on the result side; every result is checked
// against a mirrored pool kept by the scoreboard
// ----------------------------------------------------------------------------
module tb;

    import dllp_pkg::*;
    import list_pool_sb_pkg::*;

    localparam int    POOL_NODES   = 16;
    localparam int    RANDOM_ITEMS = 290;
    localparam int    PHASE_LEN    = 115;   // requests per idling phase
    localparam int    QUIET_LIMIT  = 1000;  // cycles with no transfer at all
    localparam int    DRAIN_CYCLES = 40;    // longer than any walk of the pool
    localparam data_t DATA_MIN     = 32'sh8000_0000;
    localparam data_t DATA_MAX     = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;

    dllp_req_if req_ch ();
    dllp_rsp_if rsp_ch ();

    doubly_linked_list_pool #(
        .POOL_NODES (POOL_NODES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_pool_scoreboard #(POOL_NODES) sb;

    int    sent_items = 0;   // accepted requests so far
    int    req_idle_pct = 17;
    int    rsp_stall_pct = 54;
    data_t stored_vals[$];   // values offered to inserts, reused as keys

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one request: optional idle gap, then hold valid until the transfer
    task automatic send_request(kind_t kind, data_t value, data_t key);
        int gap;
        gap = 0;
        while ($urandom_range(99) < req_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        req_ch.key   <= key;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        // transfer done at this edge
        sb.apply_request(kind, value, key);
        if (kind < KIND_READ_OUT)
            stored_vals.push_back(value);
        sent_items++;
        // idling phases: sender light / receiver heavy, then swapped, then none
        if (sent_items < PHASE_LEN)
        begin
            req_idle_pct  = 17;
            rsp_stall_pct = 54;
        end
        else if (sent_items < 2 * PHASE_LEN)
        begin
            req_idle_pct  = 54;
            rsp_stall_pct = 17;
        end
        else
        begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
        end
    endtask

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.status, rsp_ch.element, rsp_ch.last);
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // watchdog: too long without any transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int    random_sent;
        int    pick;
        kind_t kind;
        data_t value;
        data_t key;

        sb = new();
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_INS_HEAD;
        req_ch.value <= '0;
        req_ch.key   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: read out, and key searches that cannot hit
        send_request(KIND_READ_OUT, '0, '0);
        send_request(KIND_INS_AFTER, 32'sd5, DATA_MIN);
        send_request(KIND_INS_BEFORE, 32'sd6, DATA_MAX);
        // unused kinds are dropped
        send_request(3'd5, 32'sd1, 32'sd1);
        send_request(3'd6, DATA_MAX, DATA_MIN);
        send_request(3'd7, DATA_MIN, DATA_MAX);
        // tail insert into an empty list, then head inserts at the extremes
        send_request(KIND_INS_TAIL, DATA_MAX, '0);
        send_request(KIND_INS_HEAD, DATA_MIN, '0);
        send_request(KIND_INS_HEAD, 32'sd0, '0);
        // after the tail node, before the second node
        send_request(KIND_INS_AFTER, 32'sd1, DATA_MAX);
        send_request(KIND_INS_BEFORE, -32'sd1, DATA_MIN);
        // duplicate keys: the first match from the head is taken
        send_request(KIND_INS_HEAD, 32'sd1, '0);
        send_request(KIND_INS_AFTER, 32'sd2, 32'sd1);
        send_request(KIND_INS_BEFORE, 32'sd3, 32'sd1);
        // middle of the list
        send_request(KIND_INS_AFTER, 32'sd4, 32'sd0);
        send_request(KIND_INS_TAIL, 32'sd5, '0);
        // missing key on a populated list takes no node
        send_request(KIND_INS_AFTER, 32'sd7, 32'sd12345);
        send_request(KIND_INS_BEFORE, 32'sd8, -32'sd12345);
        send_request(KIND_READ_OUT, '0, '0);

        // random part: the pool fills early, after that inserts report a
        // full pool and read outs walk the whole list
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                kind = kind_t'(5 + $urandom_range(2));
            else if (pick < 30)
                kind = KIND_READ_OUT;
            else
                kind = kind_t'($urandom_range(3));
            case ($urandom_range(9))
                0: value = DATA_MIN;
                1: value = DATA_MAX;
                2: value = stored_vals[$urandom_range(stored_vals.size() - 1)];
                default: value = data_t'($urandom);
            endcase
            // mostly keys that are likely present
            if ($urandom_range(9) < 7)
                key = stored_vals[$urandom_range(stored_vals.size() - 1)];
            else
                key = data_t'($urandom);
            send_request(kind, value, key);
            if (kind <= KIND_READ_OUT)
                random_sent++;
        end
        req_ch.valid <= 1'b0;

        // let every awaited result arrive, then watch for strays
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule : tb
